FILE: src/rpc_pkg.sv
package rpc_pkg;

    // field and datapath widths
    localparam int VAL_W      = 32;
    localparam int GUARD_BITS = 16;
    localparam int XY_W       = 51;   // coordinates times 2^16 plus cordic growth
    localparam int Z_W        = 34;   // angles in units of 2^-30 rad
    localparam int RED_W      = 62;   // |angle| times 2^30
    localparam int RED_STEPS  = 13;   // quotient bits of |angle| * 2^30 / (2*pi * 2^46)
    localparam int REM_W      = 50;   // signed remainder, units of 2^-46 rad

    typedef logic signed [VAL_W-1:0] value_t;
    typedef logic signed [XY_W-1:0]  coord_t;
    typedef logic signed [Z_W-1:0]   angle_t;

    localparam angle_t PI_30      = 34'sd3373259426;
    localparam angle_t HALF_PI_30 = 34'sd1686629713;

    localparam logic [48:0] TWO_PI_46 = 49'h1_921F_B544_42D2;
    localparam logic [48:0] PI_46     = 49'h0_C90F_DAA2_2169;

    // 1/K in Q31
    localparam logic [30:0] INV_GAIN = 31'd1304065748;

    // floor(atan(2^-i) * 2^30)
    localparam logic [29:0] ATAN_TAB [32] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127,
        30'd63,        30'd31,        30'd15,        30'd7,
        30'd3,         30'd1,         30'd0,         30'd0
    };

    // one item inside the cordic pipeline; mode 1 is rectangular to polar
    typedef struct packed {
        logic   mode;
        coord_t x;
        coord_t y;
        angle_t z;
        logic   x0_zero;
        logic   y0_zero;
        logic   x0_neg;
        logic   y0_neg;
    } rpc_item_t;

    typedef struct packed {
        logic      valid;
        rpc_item_t item;
    } rpc_beat_t;

endpackage

FILE: src/rpc_in_if.sv
interface rpc_in_if;
    logic            valid;
    logic            ready;
    rpc_pkg::value_t first_value;
    rpc_pkg::value_t second_value;

    modport source (output valid, output first_value, output second_value, input ready);
    modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

FILE: src/rpc_out_if.sv
interface rpc_out_if;
    logic            valid;
    logic            ready;
    rpc_pkg::value_t first_result;
    rpc_pkg::value_t second_result;
    logic            saturated;

    modport source (output valid, output first_result, output second_result,
                    output saturated, input ready);
    modport sink   (input valid, input first_result, input second_result,
                    input saturated, output ready);
endinterface

FILE: src/rpc_angle_reduce.sv
module rpc_angle_reduce (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic               in_mode,
    input  rpc_pkg::value_t    in_first,
    input  rpc_pkg::value_t    in_second,
    output rpc_pkg::rpc_beat_t beat_out
);
    import rpc_pkg::*;

    typedef struct packed {
        logic             valid;
        logic             mode;
        value_t           a;
        value_t           b;
        logic [RED_W-1:0] r;
    } div_t;

    typedef struct packed {
        logic                    valid;
        logic                    mode;
        value_t                  a;
        value_t                  b;
        logic signed [REM_W-1:0] rem;
    } sgn_t;

    typedef struct packed {
        logic   valid;
        logic   mode;
        value_t a;
        value_t b;
        angle_t z;
    } wrp_t;

    localparam logic signed [REM_W-1:0] TWO_PI_S  = REM_W'(TWO_PI_46);
    localparam logic signed [REM_W-1:0] PI_S      = REM_W'(PI_46);
    localparam logic signed [REM_W-1:0] REM_ROUND = REM_W'(64'h8000);

    div_t      div_reg  [0:RED_STEPS];
    div_t      div_next [0:RED_STEPS];
    sgn_t      sgn_reg, sgn_next;
    wrp_t      wrp_reg, wrp_next;
    rpc_beat_t beat_reg, beat_next;

    // magnitude of the angle times 2^30, then one restoring step per stage
    always_comb
    begin
        logic [VAL_W-1:0] b_mag;
        b_mag = in_second[VAL_W-1] ? VAL_W'(-in_second) : VAL_W'(in_second);
        div_next[0].valid = in_valid;
        div_next[0].mode  = in_mode;
        div_next[0].a     = in_first;
        div_next[0].b     = in_second;
        div_next[0].r     = {b_mag, 30'b0};
        for (int j = 1; j <= RED_STEPS; j++)
        begin
            div_next[j] = div_reg[j-1];
            if (div_reg[j-1].r >= (RED_W'(TWO_PI_46) << (RED_STEPS - j)))
            begin
                div_next[j].r = div_reg[j-1].r - (RED_W'(TWO_PI_46) << (RED_STEPS - j));
            end
        end
    end

    // remainder takes the sign of the angle
    always_comb
    begin
        logic signed [REM_W-1:0] rem_mag;
        rem_mag        = REM_W'(div_reg[RED_STEPS].r);
        sgn_next.valid = div_reg[RED_STEPS].valid;
        sgn_next.mode  = div_reg[RED_STEPS].mode;
        sgn_next.a     = div_reg[RED_STEPS].a;
        sgn_next.b     = div_reg[RED_STEPS].b;
        sgn_next.rem   = div_reg[RED_STEPS].b[VAL_W-1] ? -rem_mag : rem_mag;
    end

    // wrap into [-pi, pi] and round to 2^-30 rad
    always_comb
    begin
        logic signed [REM_W-1:0] rem;
        logic signed [REM_W-1:0] rem_w;
        logic signed [REM_W-1:0] rnd;
        rem = sgn_reg.rem;
        if (rem > PI_S)
        begin
            rem_w = rem - TWO_PI_S;
        end
        else if (rem < -PI_S)
        begin
            rem_w = rem + TWO_PI_S;
        end
        else
        begin
            rem_w = rem;
        end
        rnd            = rem_w + REM_ROUND;
        wrp_next.valid = sgn_reg.valid;
        wrp_next.mode  = sgn_reg.mode;
        wrp_next.a     = sgn_reg.a;
        wrp_next.b     = sgn_reg.b;
        wrp_next.z     = Z_W'(rnd >>> 16);
    end

    // starting vector for either direction
    always_comb
    begin
        value_t a;
        value_t b;
        coord_t xa;
        coord_t ya;
        angle_t z;
        a  = wrp_reg.a;
        b  = wrp_reg.b;
        xa = {{(XY_W-VAL_W-GUARD_BITS){a[VAL_W-1]}}, a, {GUARD_BITS{1'b0}}};
        ya = {{(XY_W-VAL_W-GUARD_BITS){b[VAL_W-1]}}, b, {GUARD_BITS{1'b0}}};
        z  = wrp_reg.z;
        beat_next.valid        = wrp_reg.valid;
        beat_next.item.mode    = wrp_reg.mode;
        beat_next.item.x0_zero = (a == '0);
        beat_next.item.y0_zero = (b == '0);
        beat_next.item.x0_neg  = a[VAL_W-1];
        beat_next.item.y0_neg  = b[VAL_W-1];
        if (wrp_reg.mode)
        begin
            // left half plane: turn by pi first
            if (a[VAL_W-1])
            begin
                beat_next.item.x = -xa;
                beat_next.item.y = -ya;
                beat_next.item.z = b[VAL_W-1] ? -PI_30 : PI_30;
            end
            else
            begin
                beat_next.item.x = xa;
                beat_next.item.y = ya;
                beat_next.item.z = '0;
            end
        end
        else
        begin
            beat_next.item.y = '0;
            // angle beyond a quarter turn: turn by pi and flip the radius
            if (z > HALF_PI_30)
            begin
                beat_next.item.x = -xa;
                beat_next.item.z = z - PI_30;
            end
            else if (z < -HALF_PI_30)
            begin
                beat_next.item.x = -xa;
                beat_next.item.z = z + PI_30;
            end
            else
            begin
                beat_next.item.x = xa;
                beat_next.item.z = z;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= RED_STEPS; j++)
            begin
                div_reg[j].valid <= 1'b0;
            end
            sgn_reg.valid  <= 1'b0;
            wrp_reg.valid  <= 1'b0;
            beat_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            for (int j = 0; j <= RED_STEPS; j++)
            begin
                div_reg[j] <= div_next[j];
            end
            sgn_reg  <= sgn_next;
            wrp_reg  <= wrp_next;
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;

endmodule

FILE: src/rpc_cordic_stage.sv
module rpc_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  rpc_pkg::rpc_beat_t beat_in,
    output rpc_pkg::rpc_beat_t beat_out
);
    import rpc_pkg::*;

    localparam angle_t ANG = Z_W'(ATAN_TAB[STEP]);

    rpc_beat_t beat_reg, beat_next;

    always_comb
    begin
        coord_t x;
        coord_t y;
        angle_t z;
        coord_t xs;
        coord_t ys;
        logic   rot_pos;
        x  = beat_in.item.x;
        y  = beat_in.item.y;
        z  = beat_in.item.z;
        xs = x >>> STEP;
        ys = y >>> STEP;
        // vectoring drives y to zero, rotation drives z to zero
        rot_pos   = beat_in.item.mode ? y[XY_W-1] : ~z[Z_W-1];
        beat_next = beat_in;
        if (rot_pos)
        begin
            beat_next.item.x = x - ys;
            beat_next.item.y = y + xs;
            beat_next.item.z = z - ANG;
        end
        else
        begin
            beat_next.item.x = x + ys;
            beat_next.item.y = y - xs;
            beat_next.item.z = z + ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;

endmodule

FILE: src/rpc_finish.sv
module rpc_finish #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rpc_pkg::rpc_beat_t beat_in,
    output logic               adv,
    rpc_out_if.source          out_ch
);
    import rpc_pkg::*;

    localparam int ANG_W   = Z_W - 14;
    localparam int PPL_W   = 32 + 31;
    localparam int PPH_W   = XY_W - 32 + 31;
    localparam int MAG_W   = PPH_W + 1 - 15;
    localparam int RES_W   = MAG_W + 1;
    localparam int CLAMP_W = (VALUE_WIDTH > VAL_W) ? VAL_W : VALUE_WIDTH;

    localparam logic signed [RES_W-1:0] SAT_HI = RES_W'((64'sd1 <<< (CLAMP_W - 1)) - 64'sd1);
    localparam logic signed [RES_W-1:0] SAT_LO = -SAT_HI - RES_W'(1);
    localparam logic [63:0]             ROUND_HALF = 64'h0000_4000_0000_0000;
    localparam angle_t                  ANG_ROUND  = 34'sd8192;

    typedef struct packed {
        logic                    valid;
        logic                    mode;
        logic                    sx;
        logic                    sy;
        logic [XY_W-1:0]         mx;
        logic [XY_W-1:0]         my;
        logic signed [ANG_W-1:0] ang;
    } f0_t;

    typedef struct packed {
        logic                    valid;
        logic                    mode;
        logic                    sx;
        logic                    sy;
        logic [PPL_W-1:0]        pxl;
        logic [PPL_W-1:0]        pyl;
        logic [PPH_W-1:0]        pxh;
        logic [PPH_W-1:0]        pyh;
        logic signed [ANG_W-1:0] ang;
    } f1_t;

    typedef struct packed {
        logic                    valid;
        logic                    mode;
        logic                    sx;
        logic                    sy;
        logic [MAG_W-1:0]        magx;
        logic [MAG_W-1:0]        magy;
        logic signed [ANG_W-1:0] ang;
    } f2_t;

    typedef struct packed {
        value_t first;
        value_t second;
        logic   sat;
    } res_t;

    typedef struct packed {
        logic   sat;
        value_t value;
    } clamp_t;

    function automatic clamp_t clamp_val(input logic signed [RES_W-1:0] v);
        clamp_t c;
        c.sat   = 1'b0;
        c.value = v[VAL_W-1:0];
        if (v > SAT_HI)
        begin
            c.sat   = 1'b1;
            c.value = SAT_HI[VAL_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            c.sat   = 1'b1;
            c.value = SAT_LO[VAL_W-1:0];
        end
        return c;
    endfunction

    f0_t  f0_reg, f0_next;
    f1_t  f1_reg, f1_next;
    f2_t  f2_reg, f2_next;
    res_t res_next;
    res_t main_reg, skid_reg;
    logic main_valid_reg, skid_valid_reg;
    logic push, pop;

    // magnitudes for the gain multiply, final angle with its special cases
    always_comb
    begin
        coord_t x;
        coord_t y;
        angle_t zc;
        angle_t zr;
        x  = beat_in.item.x;
        y  = beat_in.item.y;
        zc = beat_in.item.z;
        if (zc > PI_30)
        begin
            zc = PI_30;
        end
        else if (zc < -PI_30)
        begin
            zc = -PI_30;
        end
        if (beat_in.item.x0_zero)
        begin
            if (beat_in.item.y0_zero)
            begin
                zc = '0;
            end
            else
            begin
                zc = beat_in.item.y0_neg ? -HALF_PI_30 : HALF_PI_30;
            end
        end
        else if (beat_in.item.y0_zero)
        begin
            zc = beat_in.item.x0_neg ? PI_30 : '0;
        end
        zr = zc + ANG_ROUND;
        f0_next.valid = beat_in.valid;
        f0_next.mode  = beat_in.item.mode;
        f0_next.sx    = x[XY_W-1];
        f0_next.sy    = y[XY_W-1];
        f0_next.mx    = x[XY_W-1] ? XY_W'(-x) : XY_W'(x);
        f0_next.my    = y[XY_W-1] ? XY_W'(-y) : XY_W'(y);
        f0_next.ang   = ANG_W'(zr >>> 14);
    end

    // partial products of the gain correction
    always_comb
    begin
        f1_next.valid = f0_reg.valid;
        f1_next.mode  = f0_reg.mode;
        f1_next.sx    = f0_reg.sx;
        f1_next.sy    = f0_reg.sy;
        f1_next.ang   = f0_reg.ang;
        f1_next.pxl   = PPL_W'(f0_reg.mx[31:0]) * PPL_W'(INV_GAIN);
        f1_next.pyl   = PPL_W'(f0_reg.my[31:0]) * PPL_W'(INV_GAIN);
        f1_next.pxh   = PPH_W'(f0_reg.mx[XY_W-1:32]) * PPH_W'(INV_GAIN);
        f1_next.pyh   = PPH_W'(f0_reg.my[XY_W-1:32]) * PPH_W'(INV_GAIN);
    end

    // combine and round to nearest
    always_comb
    begin
        logic [63:0]      lox;
        logic [63:0]      loy;
        logic [PPH_W:0]   sumx;
        logic [PPH_W:0]   sumy;
        lox  = 64'(f1_reg.pxl) + ROUND_HALF;
        loy  = 64'(f1_reg.pyl) + ROUND_HALF;
        sumx = (PPH_W+1)'(f1_reg.pxh) + (PPH_W+1)'(lox[63:32]);
        sumy = (PPH_W+1)'(f1_reg.pyh) + (PPH_W+1)'(loy[63:32]);
        f2_next.valid = f1_reg.valid;
        f2_next.mode  = f1_reg.mode;
        f2_next.sx    = f1_reg.sx;
        f2_next.sy    = f1_reg.sy;
        f2_next.ang   = f1_reg.ang;
        f2_next.magx  = sumx[PPH_W:15];
        f2_next.magy  = sumy[PPH_W:15];
    end

    // restore sign and clamp to the output range
    always_comb
    begin
        logic signed [RES_W-1:0] vx;
        logic signed [RES_W-1:0] vy;
        logic signed [RES_W-1:0] va;
        clamp_t                  c0;
        clamp_t                  c1;
        vx = $signed({1'b0, f2_reg.magx});
        vy = $signed({1'b0, f2_reg.magy});
        va = {{(RES_W-ANG_W){f2_reg.ang[ANG_W-1]}}, f2_reg.ang};
        if (f2_reg.sx)
        begin
            vx = -vx;
        end
        if (f2_reg.sy)
        begin
            vy = -vy;
        end
        c0 = clamp_val(vx);
        c1 = clamp_val(f2_reg.mode ? va : vy);
        res_next.first  = c0.value;
        res_next.second = c1.value;
        res_next.sat    = c0.sat | c1.sat;
    end

    assign adv  = ~skid_valid_reg;
    assign push = adv & f2_reg.valid;
    assign pop  = main_valid_reg & out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_reg.valid <= 1'b0;
            f1_reg.valid <= 1'b0;
            f2_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            f0_reg <= f0_next;
            f1_reg <= f1_next;
            f2_reg <= f2_next;
        end
    end

    // output register with a skid slot behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg       <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_reg       <= res_next;
                main_valid_reg <= 1'b1;
            end
            else
            begin
                skid_reg       <= res_next;
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid         = main_valid_reg;
    assign out_ch.first_result  = main_reg.first;
    assign out_ch.second_result = main_reg.second;
    assign out_ch.saturated     = main_reg.sat;

endmodule

FILE: src/rect_polar_converter_top.sv
// pipeline: an accepted input beat passes the input stage, 13 modulo steps,
//   3 wrap/start stages, CORDIC_STEPS cordic stages, 3 gain stages and the
//   output register on its way to its result beat
// throughput: one beat per cycle while the skid slot is empty, set by the fully
//   unrolled pipeline with one cordic iteration and one modulo step in each stage
// reset: rst_n clears all valid bits and sets convert_mode to rectangular to polar
module rect_polar_converter_top #(
    parameter int CORDIC_STEPS = 24,   // cordic stages, 8 to 32
    parameter int VALUE_WIDTH  = 32    // results clamp to min(VALUE_WIDTH, 32) signed bits
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    rpc_in_if.sink    in_ch,
    rpc_out_if.source out_ch
);
    import rpc_pkg::*;

    // convert_mode: 1 rectangular to polar, 0 polar to rectangular
    logic mode_reg;

    // whole pipeline moves together; it holds only while the skid slot is full,
    // so a result waiting at the output does not block new beats
    logic adv;

    // stage_beat[0] is the start vector, stage_beat[i+1] leaves cordic step i
    rpc_beat_t stage_beat [0:CORDIC_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    assign in_ch.ready = adv;

    // front end: mode is sampled per beat and travels with it; polar beats get
    // their angle reduced mod 2*pi and folded into a quarter turn, rectangular
    // beats in the left half plane are turned by pi
    rpc_angle_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_ch.valid),
        .in_mode   (mode_reg),
        .in_first  (in_ch.first_value),
        .in_second (in_ch.second_value),
        .beat_out  (stage_beat[0])
    );

    // one shift-add iteration per stage; vectoring in rectangular to polar,
    // rotation in polar to rectangular, same adders for both
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        rpc_cordic_stage #(
            .STEP (i)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .beat_in  (stage_beat[i]),
            .beat_out (stage_beat[i+1])
        );
    end

    // gain correction in split partial products, angle special cases,
    // clamping with the saturated flag, output register and skid slot
    rpc_finish #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_finish (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat_in (stage_beat[CORDIC_STEPS]),
        .adv     (adv),
        .out_ch  (out_ch)
    );

endmodule

FILE: test/tb.sv
module tb;
    import rpc_pkg::value_t;

    // conversion direction, as held in the mode register
    localparam logic MODE_TO_RECT  = 1'b0;
    localparam logic MODE_TO_POLAR = 1'b1;

    // which fields of a directed row carry a hand-written expectation
    localparam logic [2:0] TYPED_NONE   = 3'b000;
    localparam logic [2:0] TYPED_FIRST  = 3'b001;
    localparam logic [2:0] TYPED_SECOND = 3'b010;
    localparam logic [2:0] TYPED_SAT    = 3'b100;
    localparam logic [2:0] TYPED_ALL    = 3'b111;

    localparam value_t VMAX = 32'sh7FFF_FFFF;
    localparam value_t VMIN = 32'sh8000_0000;
    localparam value_t Q16_ONE = 32'sd65536;
    localparam value_t Q16_HALF_PI = 32'sd102944;
    localparam value_t Q16_PI = 32'sd205887;

    // fixed-point constants of the datapath
    localparam int     STEPS = 24;
    localparam longint PI_Q30 = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint PI_Q46 = 64'sh0000_C90F_DAA2_2169;
    localparam longint TWO_PI_Q46 = 64'sh0001_921F_B544_42D2;
    localparam logic [63:0] INV_GAIN_Q31 = 64'd1304065748;
    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;

    // cycles with no beat on either side before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // drain time after the last result, a bit over the pipeline depth
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 215;

    typedef struct packed {
        value_t first_res;
        value_t second_res;
        logic   sat;
    } conv_result_t;

    typedef struct {
        logic       mode;
        value_t     a;
        value_t     b;
        logic [2:0] typed;
        value_t     e_first;
        value_t     e_second;
        logic       e_sat;
    } stim_row_t;

    // floor(atan(2^-i) * 2^30), one entry per cordic step
    longint arctan_q30 [STEPS] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127
    };

    // directed rows, grouped by mode so the register changes only once
    stim_row_t directed_rows [25] = '{
        // origin gives zero everything
        '{MODE_TO_POLAR, 0, 0, TYPED_ALL, 0, 0, 1'b0},
        // x zero: angle is exactly plus or minus pi/2
        '{MODE_TO_POLAR, 0, Q16_ONE, TYPED_SECOND, 0, Q16_HALF_PI, 1'b0},
        '{MODE_TO_POLAR, 0, -Q16_ONE, TYPED_SECOND, 0, -Q16_HALF_PI, 1'b0},
        '{MODE_TO_POLAR, 0, VMAX, TYPED_SECOND, 0, Q16_HALF_PI, 1'b0},
        '{MODE_TO_POLAR, 0, VMIN, TYPED_SECOND, 0, -Q16_HALF_PI, 1'b0},
        // y zero: angle 0 for positive x, pi for negative x
        '{MODE_TO_POLAR, Q16_ONE, 0, TYPED_SECOND, 0, 0, 1'b0},
        '{MODE_TO_POLAR, -Q16_ONE, 0, TYPED_SECOND, 0, Q16_PI, 1'b0},
        '{MODE_TO_POLAR, VMIN, 0, TYPED_SECOND, 0, Q16_PI, 1'b0},
        // magnitude beyond the range clamps and flags
        '{MODE_TO_POLAR, VMAX, VMAX, TYPED_FIRST | TYPED_SAT, VMAX, 0, 1'b1},
        '{MODE_TO_POLAR, VMIN, VMIN, TYPED_FIRST | TYPED_SAT, VMAX, 0, 1'b1},
        '{MODE_TO_POLAR, VMIN, VMAX, TYPED_FIRST | TYPED_SAT, VMAX, 0, 1'b1},
        // negative x on both sides of the axis, tiny vectors
        '{MODE_TO_POLAR, -Q16_ONE, 1, TYPED_NONE, 0, 0, 1'b0},
        '{MODE_TO_POLAR, -Q16_ONE, -1, TYPED_NONE, 0, 0, 1'b0},
        '{MODE_TO_POLAR, 1, -1, TYPED_NONE, 0, 0, 1'b0},
        '{MODE_TO_POLAR, -1, -1, TYPED_NONE, 0, 0, 1'b0},
        // zero magnitude stays at the origin whatever the angle, then unit magnitude at angle zero
        '{MODE_TO_RECT, 0, VMAX, TYPED_ALL, 0, 0, 1'b0},
        '{MODE_TO_RECT, 0, VMIN, TYPED_ALL, 0, 0, 1'b0},
        '{MODE_TO_RECT, Q16_ONE, 0, TYPED_NONE, 0, 0, 1'b0},
        // angles past pi/2 get turned by pi
        '{MODE_TO_RECT, Q16_ONE, Q16_PI, TYPED_NONE, 0, 0, 1'b0},
        '{MODE_TO_RECT, Q16_ONE, -Q16_PI, TYPED_NONE, 0, 0, 1'b0},
        // negative magnitude flips the point
        '{MODE_TO_RECT, -Q16_ONE, Q16_HALF_PI, TYPED_NONE, 0, 0, 1'b0},
        // full-scale magnitudes; large angles exercise the modulo reduction
        '{MODE_TO_RECT, VMAX, VMAX, TYPED_NONE, 0, 0, 1'b0},
        '{MODE_TO_RECT, VMIN, VMIN, TYPED_NONE, 0, 0, 1'b0},
        '{MODE_TO_RECT, VMAX, 0, TYPED_NONE, 0, 0, 1'b0},
        '{MODE_TO_RECT, VMIN, 32'sd411775, TYPED_NONE, 0, 0, 1'b0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    rpc_in_if  in_ch ();
    rpc_out_if out_ch ();

    rect_polar_converter_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #4 clk = ~clk;

    // mirror of the mode register, changed only while the pipeline is empty
    logic         model_mode = MODE_TO_POLAR;
    // results owed by the block, oldest first
    conv_result_t pending_results [$];
    int           mismatch_count = 0;
    int           stall_cycles = 0;
    // set for stretches where neither side idles
    bit           no_idle = 1'b0;

    // rounded multiply by the inverse cordic gain, halves away from zero
    function automatic longint gain_round(input longint v);
        logic [63:0] m;
        logic [63:0] hi;
        logic [63:0] lo;
        longint      r;
        m = (v < 0) ? -v : v;
        hi = (m >> 32) * INV_GAIN_Q31;
        lo = (m & 64'hFFFF_FFFF) * INV_GAIN_Q31 + (64'd1 << 46);
        r = $signed((hi + (lo >> 32)) >> 15);
        return (v < 0) ? -r : r;
    endfunction

    function automatic value_t clamp_q16(input longint v, inout logic hit);
        if (v > Q_HI)
        begin
            hit = 1'b1;
            return VMAX;
        end
        if (v < Q_LO)
        begin
            hit = 1'b1;
            return VMIN;
        end
        return value_t'(v);
    endfunction

    // bit-exact expectation of one conversion
    function automatic conv_result_t predict_conversion(input logic mode,
                                                         input value_t a,
                                                         input value_t b);
        longint       x0;
        longint       y0;
        longint       x;
        longint       y;
        longint       z;
        longint       xs;
        longint       ys;
        longint       rem;
        longint       r0;
        longint       r1;
        logic         hit;
        conv_result_t res;
        x0 = a;
        y0 = b;
        hit = 1'b0;
        if (mode == MODE_TO_POLAR)
        begin
            x = x0 <<< 16;
            y = y0 <<< 16;
            z = 0;
            // left half plane: rotate by pi first
            if (x0 < 0)
            begin
                z = (y0 >= 0) ? PI_Q30 : -PI_Q30;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x += ys;
                    y -= xs;
                    z += arctan_q30[i];
                end
                else
                begin
                    x -= ys;
                    y += xs;
                    z -= arctan_q30[i];
                end
            end
            if (z > PI_Q30)
                z = PI_Q30;
            if (z < -PI_Q30)
                z = -PI_Q30;
            r0 = gain_round(x);
            // exact angles on the axes
            if (x0 == 0)
                z = (y0 > 0) ? HALF_PI_Q30 : ((y0 < 0) ? -HALF_PI_Q30 : 0);
            else if (y0 == 0)
                z = (x0 > 0) ? 0 : PI_Q30;
            r1 = (z + (64'sd1 <<< 13)) >>> 14;
        end
        else
        begin
            // reduce the angle into [-pi, pi] at 2^-46, then round to 2^-30
            rem = (y0 <<< 30) % TWO_PI_Q46;
            if (rem > PI_Q46)
                rem -= TWO_PI_Q46;
            else if (rem < -PI_Q46)
                rem += TWO_PI_Q46;
            z = (rem + (64'sd1 <<< 15)) >>> 16;
            x = x0 <<< 16;
            y = 0;
            if (z > HALF_PI_Q30)
            begin
                z -= PI_Q30;
                x = -x;
            end
            else if (z < -HALF_PI_Q30)
            begin
                z += PI_Q30;
                x = -x;
            end
            for (int i = 0; i < STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0)
                begin
                    x -= ys;
                    y += xs;
                    z -= arctan_q30[i];
                end
                else
                begin
                    x += ys;
                    y -= xs;
                    z += arctan_q30[i];
                end
            end
            r0 = gain_round(x);
            r1 = gain_round(y);
        end
        res.first_res = clamp_q16(r0, hit);
        res.second_res = clamp_q16(r1, hit);
        res.sat = hit;
        return res;
    endfunction

    function automatic value_t rand_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return value_t'($urandom);
            4:
            begin
                case ($urandom_range(0, 4))
                    0: return VMIN;
                    1: return VMAX;
                    2: return 0;
                    3: return 1;
                    default: return -1;
                endcase
            end
            5: return 0;
            // small and medium values of either sign
            default: return value_t'($signed($urandom)) >>> $urandom_range(4, 30);
        endcase
    endfunction

    // random values, or angles clustered near multiples of pi/2 to hit the quadrant folds
    function automatic value_t rand_angle();
        int k;
        if ($urandom_range(0, 9) < 6)
            return rand_value();
        k = $urandom_range(0, 20) - 10;
        return value_t'(k * Q16_HALF_PI) + (value_t'($signed($urandom)) >>> 26);
    endfunction

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 13);
    endfunction

    // one input beat; the expectation is queued at the accepting edge
    task automatic send_pair(input value_t a, input value_t b,
                             input logic [2:0] typed, input conv_result_t hand);
        int           gap;
        conv_result_t want;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.first_value <= a;
        in_ch.second_value <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        want = predict_conversion(model_mode, a, b);
        // hand-written fields override the prediction
        if (typed & TYPED_FIRST)
            want.first_res = hand.first_res;
        if (typed & TYPED_SECOND)
            want.second_res = hand.second_res;
        if (typed & TYPED_SAT)
            want.sat = hand.sat;
        pending_results.push_back(want);
    endtask

    // register write once the pipeline has drained
    task automatic set_mode(input logic m);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        cfg_wdata <= m;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_mode = m;
    endtask

    // watchdog: count cycles without any beat
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        while (stall_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("tb failed");
        $finish;
    end

    // result side: random back-pressure, compare each beat with the oldest expectation
    initial
    begin
        conv_result_t want;
        int           stall;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.first_result !== want.first_res)
                begin
                    $error("first_result: expected %0d, got %0d",
                           want.first_res, out_ch.first_result);
                    mismatch_count++;
                end
                if (out_ch.second_result !== want.second_res)
                begin
                    $error("second_result: expected %0d, got %0d",
                           want.second_res, out_ch.second_result);
                    mismatch_count++;
                end
                if (out_ch.saturated !== want.sat)
                begin
                    $error("saturated: expected %0d, got %0d",
                           want.sat, out_ch.saturated);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus: directed table, then random phases alternating the mode
    initial
    begin
        value_t       a;
        value_t       b;
        conv_result_t hand;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.first_value = '0;
        in_ch.second_value = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[idx])
        begin
            if (directed_rows[idx].mode != model_mode)
                set_mode(directed_rows[idx].mode);
            hand.first_res = directed_rows[idx].e_first;
            hand.second_res = directed_rows[idx].e_second;
            hand.sat = directed_rows[idx].e_sat;
            send_pair(directed_rows[idx].a, directed_rows[idx].b,
                      directed_rows[idx].typed, hand);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_mode((p % 2 == 0) ? MODE_TO_RECT : MODE_TO_POLAR);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // occasional stretches at full rate on both sides
                if (n % 40 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                a = rand_value();
                b = (model_mode == MODE_TO_RECT) ? rand_angle() : rand_value();
                send_pair(a, b, TYPED_NONE, '0);
            end
        end
        no_idle = 1'b0;

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // stray beats after the last expected one still count as failures
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
